// File: src/nnz_pkg.sv
// Shared types and constants for the nearest-neighbor zoom block.
`default_nettype none
package nnz_pkg;

  // Field and register widths
  localparam int COORD_W    = 8;
  localparam int VAL_W      = 16;
  localparam int DIM_W      = 9;
  localparam int STEP_W     = 24;
  localparam int PROD_W     = COORD_W + STEP_W;
  localparam int FRAC_W     = 16;
  localparam int INT_W      = PROD_W - FRAC_W;
  // Effective sizes cover register values and the largest image limits
  localparam int SIZE_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP     = 3'd5;

  // Mapped request handed from the mapping stage to the store
  typedef struct packed {
    logic                    valid;
    logic                    cmd;
    logic                    err;
    logic [INT_W-1:0]        sx_raw;
    logic [INT_W-1:0]        sy_raw;
    logic [COORD_W-1:0]      px;
    logic [COORD_W-1:0]      py;
    logic signed [VAL_W-1:0] val;
  } map_req_t;

endpackage
`default_nettype wire

// File: src/nnz_map.sv
// Coordinate mapping stage: range checks and reciprocal-step products.
`default_nettype none
module nnz_map (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic                        in_valid,
  input  wire logic                        cmd,
  input  wire logic [nnz_pkg::COORD_W-1:0] pixel_x,
  input  wire logic [nnz_pkg::COORD_W-1:0] pixel_y,
  input  wire logic signed [nnz_pkg::VAL_W-1:0] pixel_in,
  input  wire logic [nnz_pkg::SIZE_W-1:0]  src_w_eff,
  input  wire logic [nnz_pkg::SIZE_W-1:0]  src_h_eff,
  input  wire logic [nnz_pkg::DIM_W-1:0]   dst_width,
  input  wire logic [nnz_pkg::DIM_W-1:0]   dst_height,
  input  wire logic [nnz_pkg::STEP_W-1:0]  x_step,
  input  wire logic [nnz_pkg::STEP_W-1:0]  y_step,
  output nnz_pkg::map_req_t                req
);

  logic [nnz_pkg::PROD_W-1:0] prod_x;
  logic [nnz_pkg::PROD_W-1:0] prod_y;
  logic                       load_err;
  logic                       fetch_err;
  logic                       err_next;

  // Exact products; integer part is the unclamped source coordinate
  assign prod_x = nnz_pkg::PROD_W'(pixel_x) * nnz_pkg::PROD_W'(x_step);
  assign prod_y = nnz_pkg::PROD_W'(pixel_y) * nnz_pkg::PROD_W'(y_step);

  // Range checks
  assign load_err = !((nnz_pkg::SIZE_W'(pixel_x) < src_w_eff) &&
                      (nnz_pkg::SIZE_W'(pixel_y) < src_h_eff));
  assign fetch_err = (nnz_pkg::DIM_W'(pixel_x) >= dst_width) ||
                     (nnz_pkg::DIM_W'(pixel_y) >= dst_height) ||
                     (src_w_eff == '0) || (src_h_eff == '0);
  assign err_next = (cmd == nnz_pkg::CMD_LOAD) ? load_err : fetch_err;

  // Stage register: valid is reset, payload only moves on advance
  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (adv) begin
      req.valid <= in_valid;
    end
    if (adv) begin
      req.cmd    <= cmd;
      req.err    <= err_next;
      req.sx_raw <= prod_x[nnz_pkg::PROD_W-1:nnz_pkg::FRAC_W];
      req.sy_raw <= prod_y[nnz_pkg::PROD_W-1:nnz_pkg::FRAC_W];
      req.px     <= pixel_x;
      req.py     <= pixel_y;
      req.val    <= pixel_in;
    end
  end

endmodule
`default_nettype wire

// File: src/nnz_store.sv
// Source image memory: clamp, address, write on load, registered read on fetch.
`default_nettype none
module nnz_store #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       adv,
  input  wire nnz_pkg::map_req_t          req,
  input  wire logic [nnz_pkg::SIZE_W-1:0] src_w_eff,
  input  wire logic [nnz_pkg::SIZE_W-1:0] src_h_eff,
  output logic [nnz_pkg::VAL_W-1:0]       rd_pix
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [PIXEL_BITS-1:0]       mem [DEPTH];
  logic [PIXEL_BITS-1:0]       rdata;
  logic [nnz_pkg::INT_W-1:0]   sx;
  logic [nnz_pkg::INT_W-1:0]   sy;
  logic [nnz_pkg::INT_W-1:0]   sw_i;
  logic [nnz_pkg::INT_W-1:0]   sh_i;
  logic [ADDR_W-1:0]           fetch_addr;
  logic [ADDR_W-1:0]           load_addr;
  logic [PIXEL_BITS-1:0]       wr_pix;
  logic                        do_op;

  assign sw_i = nnz_pkg::INT_W'(src_w_eff);
  assign sh_i = nnz_pkg::INT_W'(src_h_eff);

  // Clamp to the last source column and row
  assign sx = (req.sx_raw >= sw_i) ? (sw_i - 1'b1) : req.sx_raw;
  assign sy = (req.sy_raw >= sh_i) ? (sh_i - 1'b1) : req.sy_raw;

  // Row-major addresses
  assign fetch_addr = ADDR_W'(32'(sy) * MAX_WIDTH + 32'(sx));
  assign load_addr  = ADDR_W'(32'(req.py) * MAX_WIDTH + 32'(req.px));

  // Sign-extend or truncate the load value to the stored width
  assign wr_pix = PIXEL_BITS'(req.val);

  assign do_op = adv && req.valid && !req.err;

  // Memory port: one access per beat
  always_ff @(posedge clk) begin
    if (do_op) begin
      if (req.cmd == nnz_pkg::CMD_LOAD) begin
        mem[load_addr] <= wr_pix;
      end else begin
        rdata <= mem[fetch_addr];
      end
    end
  end

  assign rd_pix = nnz_pkg::VAL_W'(rdata);

endmodule
`default_nettype wire

// File: src/nearest_neighbor_image_zoom.sv
// Top level of the nearest-neighbor image zoom block.
//
// Usage: configure the six registers through the write port (cfg_wr_en,
// cfg_addr, cfg_wr_data) while idle. Input beats carry a command: a load
// stores pixel_in at (pixel_x, pixel_y) in the source image; a fetch maps
// the destination (pixel_x, pixel_y) to the nearest source pixel through
// the Q8.16 x_step and y_step and returns it on pixel_out with status 0.
// A coordinate outside the configured sizes returns pixel_out 0 and
// status 1; a good load returns no beat.
// Pipeline: an input beat is registered in the mapping stage, after the
// step multipliers, and then in the memory read and output registers.
// Throughput: one beat per cycle while the output is not stalled; the
// single memory port serves one load or one fetch each cycle.
// Stall: a stalled output holds its beat, and the whole two-stage pipe
// halts with it, so in_stall follows out_stall while a result is waiting.
// Reset: the registers return to 256 x 256 sizes and unit steps and the
// pipe empties; the image memory is not cleared, and the user must read it
// only where it was written: the block itself does not enforce this.
`default_nettype none
module nearest_neighbor_image_zoom #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [nnz_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [nnz_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            cmd,
  input  wire logic [nnz_pkg::COORD_W-1:0]     pixel_x,
  input  wire logic [nnz_pkg::COORD_W-1:0]     pixel_y,
  input  wire logic signed [nnz_pkg::VAL_W-1:0] pixel_in,
  // output channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [nnz_pkg::VAL_W-1:0]     pixel_out,
  output logic                                 status
);

  logic [nnz_pkg::DIM_W-1:0]  src_width;
  logic [nnz_pkg::DIM_W-1:0]  src_height;
  logic [nnz_pkg::DIM_W-1:0]  dst_width;
  logic [nnz_pkg::DIM_W-1:0]  dst_height;
  logic [nnz_pkg::STEP_W-1:0] x_step;
  logic [nnz_pkg::STEP_W-1:0] y_step;
  logic [nnz_pkg::SIZE_W-1:0] src_w_eff;
  logic [nnz_pkg::SIZE_W-1:0] src_h_eff;
  logic                       adv;
  logic                       out_err;
  logic [nnz_pkg::VAL_W-1:0]  rd_pix;
  nnz_pkg::map_req_t          req;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= nnz_pkg::DIM_W'(256);
      src_height <= nnz_pkg::DIM_W'(256);
      dst_width  <= nnz_pkg::DIM_W'(256);
      dst_height <= nnz_pkg::DIM_W'(256);
      x_step     <= nnz_pkg::STEP_W'(65536);
      y_step     <= nnz_pkg::STEP_W'(65536);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        nnz_pkg::REG_SRC_WIDTH:  src_width  <= cfg_wr_data[nnz_pkg::DIM_W-1:0];
        nnz_pkg::REG_SRC_HEIGHT: src_height <= cfg_wr_data[nnz_pkg::DIM_W-1:0];
        nnz_pkg::REG_DST_WIDTH:  dst_width  <= cfg_wr_data[nnz_pkg::DIM_W-1:0];
        nnz_pkg::REG_DST_HEIGHT: dst_height <= cfg_wr_data[nnz_pkg::DIM_W-1:0];
        nnz_pkg::REG_X_STEP:     x_step     <= cfg_wr_data[nnz_pkg::STEP_W-1:0];
        nnz_pkg::REG_Y_STEP:     y_step     <= cfg_wr_data[nnz_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Source sizes limited to the memory dimensions
  assign src_w_eff = (nnz_pkg::SIZE_W'(src_width) > nnz_pkg::SIZE_W'(MAX_WIDTH)) ?
                     nnz_pkg::SIZE_W'(MAX_WIDTH) : nnz_pkg::SIZE_W'(src_width);
  assign src_h_eff = (nnz_pkg::SIZE_W'(src_height) > nnz_pkg::SIZE_W'(MAX_HEIGHT)) ?
                     nnz_pkg::SIZE_W'(MAX_HEIGHT) : nnz_pkg::SIZE_W'(src_height);

  // Pipe moves whenever the output register is free or being emptied
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  nnz_map u_map (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (in_valid),
    .cmd        (cmd),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_in   (pixel_in),
    .src_w_eff  (src_w_eff),
    .src_h_eff  (src_h_eff),
    .dst_width  (dst_width),
    .dst_height (dst_height),
    .x_step     (x_step),
    .y_step     (y_step),
    .req        (req)
  );

  nnz_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_store (
    .clk       (clk),
    .adv       (adv),
    .req       (req),
    .src_w_eff (src_w_eff),
    .src_h_eff (src_h_eff),
    .rd_pix    (rd_pix)
  );

  // Output beat: fetches and rejected items produce one, good loads none
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= req.valid && ((req.cmd == nnz_pkg::CMD_FETCH) || req.err);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_err <= req.err;
    end
  end

  assign pixel_out = out_err ? '0 : rd_pix;
  assign status    = out_err;

endmodule
`default_nettype wire
